FILE: sv/assert_macros.svh
// Assertion helpers used by the hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an implication holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/b3h_pkg.sv
package b3h_pkg;

    localparam int MAX_DEPTH_DEF = 32;
    localparam int BLK_BYTES     = 64;
    localparam int CHUNK_BLOCKS  = 16;
    localparam int ROUNDS        = 7;

    localparam logic [31:0] F_START  = 32'd1;
    localparam logic [31:0] F_END    = 32'd2;
    localparam logic [31:0] F_PARENT = 32'd4;
    localparam logic [31:0] F_ROOT   = 32'd8;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_LAST = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } in_req_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
        logic        overflow;
    } out_req_t;

    typedef logic [31:0] word_t;
    typedef word_t [7:0]  cv_t;
    typedef word_t [15:0] msg_t;

    // Compression request handed to the round engine.
    typedef struct packed {
        cv_t         cv;
        msg_t        m;
        logic [63:0] ctr;
        logic [31:0] len;
        logic [31:0] flags;
    } cmp_req_t;

    function automatic word_t iv_word(input logic [2:0] i);
        word_t w;
        unique case (i)
            3'd0: w = 32'h6A09E667;
            3'd1: w = 32'hBB67AE85;
            3'd2: w = 32'h3C6EF372;
            3'd3: w = 32'hA54FF53A;
            3'd4: w = 32'h510E527F;
            3'd5: w = 32'h9B05688C;
            3'd6: w = 32'h1F83D9AB;
            default: w = 32'h5BE0CD19;
        endcase
        return w;
    endfunction

    function automatic cv_t iv_cv();
        cv_t c;
        for (int i = 0; i < 8; i++) c[i] = iv_word(3'(i));
        return c;
    endfunction

    function automatic logic [3:0] perm(input logic [3:0] i);
        logic [3:0] p;
        unique case (i)
            4'd0: p = 4'd2;   4'd1: p = 4'd6;   4'd2: p = 4'd3;   4'd3: p = 4'd10;
            4'd4: p = 4'd7;   4'd5: p = 4'd0;   4'd6: p = 4'd4;   4'd7: p = 4'd13;
            4'd8: p = 4'd1;   4'd9: p = 4'd11;  4'd10: p = 4'd12; 4'd11: p = 4'd5;
            4'd12: p = 4'd9;  4'd13: p = 4'd14; 4'd14: p = 4'd15; default: p = 4'd8;
        endcase
        return p;
    endfunction

endpackage

FILE: sv/blake3_256_hasher.sv
// BLAKE3-256 hasher, unkeyed, one message byte per request.
// Input channel (in_valid/in_stall/in_data): kind 0 is a message byte, kind 1
// the final byte, kind 2 ends the message with no byte; kind 3 is dropped.
// Output channel (out_valid/out_stall/out_data): four 64-bit digest words,
// word_index 0..3, last_word on the fourth, overflow set if the subtree
// stack overflowed. A byte is written straight to the buffer unless the block is
// already full: then the buffer is read out into the message register 4 bytes a
// cycle, the block is compressed (one G step a cycle, 8 steps x 7 rounds) and the
// held byte is then written. A chunk end adds a stack read and a parent
// compression per merge, then a merge check and the push. End of message
// reads the open block, compresses once per stack entry and once more for
// the root, then offers the four digest words.
// The block buffer (64 bytes) and the subtree stack live in synchronous
// memories with registered read data.
// Reset clears all control state; the block buffer is cleared by a sweep
// of its 16 words after reset and after each digest, during which in_stall
// is high, and swept during each block compression. The stack needs no
// clearing. While out_stall is high the current digest word holds and no
// input is taken until all four words are delivered.
module blake3_256_hasher
    import b3h_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_req_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output out_req_t out_data
);
`include "assert_macros.svh"

    localparam int SW = $clog2(MAX_DEPTH + 1);
    localparam int SA = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_LOAD   = 11'b00000000100,
        S_CMP    = 11'b00000001000,
        S_WAIT   = 11'b00000010000,
        S_SRD    = 11'b00000100000,
        S_MERGE  = 11'b00001000000,
        S_FIN    = 11'b00010000000,
        S_FRD    = 11'b00100000000,
        S_OUT    = 11'b01000000000,
        S_ROOT   = 11'b10000000000
    } st_t;

    // What the running compression is for.
    typedef enum logic [4:0] {
        J_BLOCK  = 5'b00001,
        J_CHUNK  = 5'b00010,
        J_PARENT = 5'b00100,
        J_FOLD   = 5'b01000,
        J_ROOT   = 5'b10000
    } job_t;

    st_t         st_reg, st_next;
    job_t        job_reg, job_next;
    cv_t         cv_reg, cv_next;           // chunk chaining value
    cv_t         acc_reg, acc_next;         // value being merged / folded
    msg_t        m_reg, m_next;
    logic [6:0]  fill_reg, fill_next;
    logic [3:0]  blocks_reg, blocks_next;
    logic [63:0] chunks_reg, chunks_next;
    logic [63:0] total_reg, total_next;
    logic [SW-1:0] depth_reg, depth_next;
    logic        ovf_reg, ovf_next;
    logic [5:0]  ptr_reg, ptr_next;         // clear/load address
    logic        last_reg, last_next;       // finish after this byte
    logic [7:0]  byte_reg, byte_next;       // byte waiting for a block compress
    logic [1:0]  oidx_reg, oidx_next;
    msg_t        root_reg, root_next;
    cmp_req_t    creq;
    logic        cstart;
    logic        cbusy, cdone;
    msg_t        cres;

    // Block buffer: 16 words of 4 bytes, byte write enables.
    logic [31:0] buf_mem [16];
    logic [31:0] buf_rd_reg;
    logic        buf_we;
    logic [3:0]  buf_wa;
    logic [3:0]  buf_be;
    logic [31:0] buf_wd;
    logic [3:0]  buf_ra;

    // Subtree stack memory.
    logic [255:0] stk_mem [MAX_DEPTH];
    logic [255:0] stk_rd_reg;
    logic         stk_we;
    logic [SA-1:0] stk_wa, stk_ra;
    logic [255:0] stk_wd;

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            for (int i = 0; i < 4; i++)
                if (buf_be[i]) buf_mem[buf_wa][8 * i +: 8] <= buf_wd[8 * i +: 8];
        end
        buf_rd_reg <= buf_mem[buf_ra];
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        stk_rd_reg <= stk_mem[stk_ra];
    end

    b3h_compress u_cmp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cstart),
        .req    (creq),
        .busy   (cbusy),
        .done   (cdone),
        .result (cres)
    );

    function automatic msg_t pack_pair(input logic [255:0] l, input cv_t r);
        msg_t m;
        for (int i = 0; i < 8; i++)
        begin
            m[i]     = l[32 * i +: 32];
            m[i + 8] = r[i];
        end
        return m;
    endfunction

    function automatic logic [255:0] cv_bits(input cv_t c);
        logic [255:0] b;
        for (int i = 0; i < 8; i++) b[32 * i +: 32] = c[i];
        return b;
    endfunction

    function automatic cv_t low_cv(input msg_t w);
        cv_t c;
        for (int i = 0; i < 8; i++) c[i] = w[i];
        return c;
    endfunction

    logic [31:0] chunk_fl;
    assign chunk_fl = ((blocks_reg == 4'd0) ? F_START : 32'd0) | F_END;

    always_comb
    begin
        st_next     = st_reg;
        job_next    = job_reg;
        cv_next     = cv_reg;
        acc_next    = acc_reg;
        m_next      = m_reg;
        fill_next   = fill_reg;
        blocks_next = blocks_reg;
        chunks_next = chunks_reg;
        total_next  = total_reg;
        depth_next  = depth_reg;
        ovf_next    = ovf_reg;
        ptr_next    = ptr_reg;
        last_next   = last_reg;
        byte_next   = byte_reg;
        oidx_next   = oidx_reg;
        root_next   = root_reg;
        cstart      = 1'b0;
        creq        = '0;
        buf_we      = 1'b0;
        buf_wa      = fill_reg[5:2];
        buf_be      = 4'b0000;
        buf_wd      = {4{in_data.data_byte}};
        buf_ra      = ptr_reg[3:0];
        stk_we      = 1'b0;
        stk_wa      = depth_reg[SA-1:0];
        stk_wd      = cv_bits(acc_reg);
        stk_ra      = SA'(depth_reg - SW'(1));
        in_stall    = (st_reg != S_IDLE);

        unique case (st_reg)
            S_CLEAR:
            begin
                buf_we = 1'b1;
                buf_wa = ptr_reg[3:0];
                buf_be = 4'b1111;
                buf_wd = '0;
                ptr_next = ptr_reg + 6'd1;
                if (ptr_reg == 6'd15)
                begin
                    ptr_next = '0;
                    st_next  = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_data.kind != KIND_NONE)
                begin
                    last_next = (in_data.kind != KIND_BYTE);
                    if (in_data.kind == KIND_END)
                    begin
                        ptr_next = '0;
                        st_next  = S_LOAD;
                        job_next = J_ROOT;
                    end
                    else if (fill_reg == 7'(BLK_BYTES))
                    begin
                        byte_next = in_data.data_byte;
                        ptr_next  = '0;
                        st_next   = S_LOAD;
                        job_next  = (blocks_reg == 4'(CHUNK_BLOCKS - 1)) ? J_CHUNK : J_BLOCK;
                    end
                    else
                    begin
                        buf_we = 1'b1;
                        buf_be = 4'b0001 << fill_reg[1:0];
                        fill_next = fill_reg + 7'd1;
                        if (in_data.kind == KIND_LAST)
                        begin
                            ptr_next = '0;
                            st_next  = S_LOAD;
                            job_next = J_ROOT;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                // Read 16 words; the read data is registered.
                ptr_next = ptr_reg + 6'd1;
                if (ptr_reg != 6'd0) m_next[ptr_reg[3:0] - 4'd1] = buf_rd_reg;
                if (ptr_reg == 6'd16)
                begin
                    ptr_next = '0;
                    if (job_reg == J_ROOT)
                    begin
                        st_next = S_FIN;
                    end
                    else
                    begin
                        cstart = 1'b1;
                        creq.cv = cv_reg;
                        creq.m  = m_next;
                        creq.ctr = chunks_reg;
                        creq.len = 32'(BLK_BYTES);
                        creq.flags = (job_reg == J_CHUNK) ? chunk_fl
                                   : ((blocks_reg == 4'd0) ? F_START : 32'd0);
                        total_next = chunks_reg + 64'd1;
                        st_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                // Sweep-clear the buffer while the rounds run (compressions started from S_LOAD only).
                if (ptr_reg != 6'd16)
                begin
                    buf_we = 1'b1;
                    buf_wa = ptr_reg[3:0];
                    buf_be = 4'b1111;
                    buf_wd = '0;
                    ptr_next = ptr_reg + 6'd1;
                end
                // A fold pairs with the entry just popped; fetch it ahead of the result.
                if (job_reg == J_FOLD) stk_ra = depth_reg[SA-1:0];
                if (cdone) st_next = S_WAIT;
            end
            S_WAIT:
            begin
                ptr_next = '0;
                unique case (job_reg)
                    J_BLOCK:
                    begin
                        cv_next = low_cv(cres);
                        blocks_next = blocks_reg + 4'd1;
                        fill_next = 7'd1;
                        buf_we = 1'b1; buf_wa = 4'd0; buf_be = 4'b0001;
                        buf_wd = {24'd0, byte_reg};
                        st_next = last_reg ? S_LOAD : S_IDLE;
                        job_next = J_ROOT;
                    end
                    J_CHUNK, J_PARENT:
                    begin
                        acc_next = low_cv(cres);
                        if (job_reg == J_CHUNK)
                        begin
                            cv_next = iv_cv();
                            blocks_next = 4'd0;
                            chunks_next = total_reg;
                        end
                        else
                            total_next = total_reg >> 1;
                        st_next = S_SRD;
                    end
                    J_FOLD:
                    begin
                        acc_next = low_cv(cres);
                        st_next = S_FIN;
                    end
                    default:
                    begin
                        root_next = cres;
                        oidx_next = 2'd0;
                        st_next = S_OUT;
                    end
                endcase
            end
            S_SRD:
            begin
                // Merge while count has trailing zeros; read is issued here.
                if (!total_reg[0])
                begin
                    if (depth_reg == '0)
                    begin
                        ovf_next = 1'b1;
                        st_next = S_ROOT;
                    end
                    else
                    begin
                        depth_next = depth_reg - SW'(1);
                        st_next = S_MERGE;
                    end
                end
                else
                    st_next = S_ROOT;
            end
            S_MERGE:
            begin
                cstart = 1'b1;
                creq.cv = iv_cv();
                creq.m = pack_pair(stk_rd_reg, acc_reg);
                creq.ctr = '0;
                creq.len = 32'(BLK_BYTES);
                creq.flags = F_PARENT;
                job_next = J_PARENT;
                ptr_next = 6'd16;
                st_next = S_CMP;
            end
            S_ROOT:
            begin
                // Push the chunk result, then take the held byte.
                if (depth_reg >= SW'(MAX_DEPTH))
                    ovf_next = 1'b1;
                else
                begin
                    stk_we = 1'b1;
                    depth_next = depth_reg + SW'(1);
                end
                fill_next = 7'd1;
                buf_we = 1'b1; buf_wa = 4'd0; buf_be = 4'b0001;
                buf_wd = {24'd0, byte_reg};
                job_next = J_ROOT;
                st_next = last_reg ? S_LOAD : S_IDLE;
            end
            S_FIN:
            begin
                // m_reg holds the open block on entry from LOAD, the parent block after a fold.
                if (depth_reg == '0)
                begin
                    cstart = 1'b1;
                    if (job_reg == J_FOLD)
                    begin
                        creq.cv = iv_cv(); creq.m = m_reg; creq.len = 32'(BLK_BYTES);
                        creq.flags = F_PARENT | F_ROOT;
                    end
                    else
                    begin
                        creq.cv = cv_reg; creq.m = m_reg; creq.len = 32'(fill_reg);
                        creq.flags = chunk_fl | F_ROOT;
                    end
                    creq.ctr = '0;
                    job_next = J_ROOT;
                    ptr_next = 6'd16;
                    st_next = S_CMP;
                end
                else
                begin
                    depth_next = depth_reg - SW'(1);
                    st_next = S_FRD;
                end
            end
            S_FRD:
            begin
                // Compress the open node (non-root) then pair with stack entry.
                cstart = 1'b1;
                if (job_reg == J_FOLD)
                begin
                    creq.cv = iv_cv(); creq.m = m_reg; creq.len = 32'(BLK_BYTES);
                    creq.ctr = '0; creq.flags = F_PARENT;
                end
                else
                begin
                    creq.cv = cv_reg; creq.m = m_reg; creq.len = 32'(fill_reg);
                    creq.ctr = chunks_reg; creq.flags = chunk_fl;
                end
                job_next = J_FOLD;
                ptr_next = 6'd16;
                st_next = S_CMP;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    oidx_next = oidx_reg + 2'd1;
                    if (oidx_reg == 2'd3)
                    begin
                        cv_next = iv_cv();
                        fill_next = '0; blocks_next = '0; chunks_next = '0;
                        depth_next = '0; ovf_next = 1'b0; ptr_next = '0;
                        st_next = S_CLEAR;
                    end
                end
            end
            default: st_next = S_CLEAR;
        endcase
        // Fold step: after S_CMP returns J_FOLD, form parent block from stack.
        if (st_reg == S_WAIT && job_reg == J_FOLD)
            m_next = pack_pair(stk_rd_reg, low_cv(cres));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_CLEAR;
            job_reg    <= J_ROOT;
            cv_reg     <= iv_cv();
            fill_reg   <= '0;
            blocks_reg <= '0;
            chunks_reg <= '0;
            depth_reg  <= '0;
            ovf_reg    <= 1'b0;
            ptr_reg    <= '0;
            last_reg   <= 1'b0;
            oidx_reg   <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            job_reg    <= job_next;
            cv_reg     <= cv_next;
            fill_reg   <= fill_next;
            blocks_reg <= blocks_next;
            chunks_reg <= chunks_next;
            depth_reg  <= depth_next;
            ovf_reg    <= ovf_next;
            ptr_reg    <= ptr_next;
            last_reg   <= last_next;
            oidx_reg   <= oidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        m_reg     <= m_next;
        total_reg <= total_next;
        byte_reg  <= byte_next;
        root_reg  <= root_next;
    end

    assign out_valid = (st_reg == S_OUT);
    always_comb
    begin
        out_data.digest_word = {root_reg[{oidx_reg, 1'b1}], root_reg[{oidx_reg, 1'b0}]};
        out_data.word_index  = oidx_reg;
        out_data.last_word   = (oidx_reg == 2'd3);
        out_data.overflow    = ovf_reg;
    end

    `ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, in_stall,
        "input taken while digest pending")
    `ASSERT_IMPL(a_depth_range, clk, rst_n, 1'b1, depth_reg <= SW'(MAX_DEPTH),
        "stack depth beyond limit")
    `ASSERT_NEXT(a_cmp_start, clk, rst_n, cstart, cbusy, "compressor did not start")
    `ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_reg <= 7'(BLK_BYTES),
        "block fill beyond block size")

endmodule

FILE: sv/b3h_compress.sv
module b3h_compress
    import b3h_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cmp_req_t req,
    output logic     busy,
    output logic     done,
    output msg_t     result
);

    // One G function per cycle: 8 G steps per round, 7 rounds.
    msg_t        s_reg, s_next;
    msg_t        m_reg, m_next;
    cv_t         cv_reg;
    logic [2:0]  g_reg, g_next;
    logic [2:0]  r_reg, r_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [3:0] ia, ib, ic, id;
    word_t a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2, x, y;

    always_comb
    begin
        unique case (g_reg)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        x  = m_reg[{g_reg, 1'b0}];
        y  = m_reg[{g_reg, 1'b1}];
        a0 = s_reg[ia] + s_reg[ib] + x;
        d0 = s_reg[id] ^ a0; d0 = {d0[15:0], d0[31:16]};
        c0 = s_reg[ic] + d0;
        b0 = s_reg[ib] ^ c0; b0 = {b0[11:0], b0[31:12]};
        a1 = a0 + b0 + y;
        d1 = d0 ^ a1; d1 = {d1[7:0], d1[31:8]};
        c1 = c0 + d1;
        b1 = b0 ^ c1; b1 = {b1[6:0], b1[31:7]};
        a2 = a1; b2 = b1; c2 = c1; d2 = d1;

        s_next    = s_reg;
        m_next    = m_reg;
        g_next    = g_reg;
        r_next    = r_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            for (int i = 0; i < 8; i++) s_next[i] = req.cv[i];
            for (int i = 0; i < 4; i++) s_next[8 + i] = iv_word(3'(i));
            s_next[12] = req.ctr[31:0];
            s_next[13] = req.ctr[63:32];
            s_next[14] = req.len;
            s_next[15] = req.flags;
            m_next     = req.m;
            g_next     = 3'd0;
            r_next     = 3'd0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            s_next[ia] = a2; s_next[ib] = b2; s_next[ic] = c2; s_next[id] = d2;
            g_next = g_reg + 3'd1;
            if (g_reg == 3'd7)
            begin
                for (int i = 0; i < 16; i++) m_next[i] = m_reg[perm(4'(i))];
                r_next = r_reg + 3'd1;
                if (r_reg == 3'(ROUNDS - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            g_reg    <= 3'd0;
            r_reg    <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            g_reg    <= g_next;
            r_reg    <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        m_reg <= m_next;
        if (start && !busy_reg) cv_reg <= req.cv;
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            result[i]     = s_reg[i] ^ s_reg[i + 8];
            result[i + 8] = s_reg[i + 8] ^ cv_reg[i];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: tb/tb_blake3_256_hasher.sv
`timescale 1ns / 1ps

module tb_blake3_256_hasher;
    import b3h_pkg::*;

    // Messages stay within one chunk, so a single stack slot is enough.
    localparam int          STACK_SLOTS = 1;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          TOTAL_REQS  = 460;
    localparam cv_t IV_WORDS = {32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
                                32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

    typedef struct packed {
        logic    drain;  // hold this request until no digest is outstanding
        in_req_t req;
    } feed_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    in_req_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    out_req_t out_data;

    feed_t    feed_q[$];
    out_req_t digest_q[$];
    int       fail_count = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    int       idle_cycles = 0;
    logic     calm = 1'b0;

    // Hasher state as seen by the predictor.
    cv_t         chain_cv;
    logic [7:0]  blk_bytes[64];
    int          blk_fill;
    int          blks_in_chunk;
    logic [63:0] chunk_ctr;
    cv_t         subtree_cv[STACK_SLOTS];
    int          subtree_depth;
    logic        stack_overflow;

    int sched[16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};

    blake3_256_hasher #(.MAX_DEPTH(STACK_SLOTS)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic word_t rotr(word_t w, int c);
        return (w >> c) | (w << (32 - c));
    endfunction

    function automatic void g_step(inout word_t s[16], input int a, input int b, input int c,
                                   input int d, input word_t x, input word_t y);
        s[a] = s[a] + s[b] + x; s[d] = rotr(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d];     s[b] = rotr(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b] + y; s[d] = rotr(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d];     s[b] = rotr(s[b] ^ s[c], 7);
    endfunction

    // Full 16-word compression output.
    function automatic msg_t compress(cv_t h, msg_t m, logic [63:0] ctr, word_t len,
                                      word_t flags);
        word_t s[16];
        msg_t  t;
        msg_t  o;
        for (int i = 0; i < 8; i++) s[i] = h[i];
        for (int i = 0; i < 4; i++) s[8 + i] = IV_WORDS[i];
        s[12] = ctr[31:0];
        s[13] = ctr[63:32];
        s[14] = len;
        s[15] = flags;
        for (int r = 0; r < 7; r++)
        begin
            g_step(s, 0, 4, 8, 12, m[0], m[1]);   g_step(s, 1, 5, 9, 13, m[2], m[3]);
            g_step(s, 2, 6, 10, 14, m[4], m[5]);  g_step(s, 3, 7, 11, 15, m[6], m[7]);
            g_step(s, 0, 5, 10, 15, m[8], m[9]);  g_step(s, 1, 6, 11, 12, m[10], m[11]);
            g_step(s, 2, 7, 8, 13, m[12], m[13]); g_step(s, 3, 4, 9, 14, m[14], m[15]);
            for (int i = 0; i < 16; i++) t[i] = m[sched[i]];
            m = t;
        end
        for (int i = 0; i < 8; i++)
        begin
            o[i]     = s[i] ^ s[i + 8];
            o[i + 8] = s[i + 8] ^ h[i];
        end
        return o;
    endfunction

    function automatic cv_t low_half(msg_t w);
        cv_t c;
        for (int i = 0; i < 8; i++) c[i] = w[i];
        return c;
    endfunction

    function automatic msg_t join_cvs(cv_t l, cv_t r);
        msg_t m;
        for (int i = 0; i < 8; i++)
        begin
            m[i]     = l[i];
            m[8 + i] = r[i];
        end
        return m;
    endfunction

    function automatic msg_t buffered_block();
        msg_t m;
        for (int i = 0; i < 16; i++)
            m[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
        return m;
    endfunction

    function automatic word_t chunk_end_flags();
        return (blks_in_chunk == 0 ? F_START : 32'd0) | F_END;
    endfunction

    task automatic start_chunk(logic [63:0] ctr);
        chain_cv      = IV_WORDS;
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
        blk_fill      = 0;
        blks_in_chunk = 0;
        chunk_ctr     = ctr;
    endtask

    task automatic clear_hasher();
        start_chunk(64'd0);
        subtree_depth  = 0;
        stack_overflow = 1'b0;
    endtask

    // Merge a finished chunk with its left siblings, then push it.
    task automatic push_subtree(cv_t cv, logic [63:0] total);
        while (total[0] == 1'b0)
        begin
            if (subtree_depth == 0)
            begin
                stack_overflow = 1'b1;
                break;
            end
            subtree_depth--;
            cv = low_half(compress(IV_WORDS, join_cvs(subtree_cv[subtree_depth], cv), 64'd0,
                                   32'd64, F_PARENT));
            total = total >> 1;
        end
        if (subtree_depth >= STACK_SLOTS)
            stack_overflow = 1'b1;
        else
        begin
            subtree_cv[subtree_depth] = cv;
            subtree_depth++;
        end
    endtask

    task automatic hash_byte(logic [7:0] b);
        logic [63:0] total;
        if (blks_in_chunk == CHUNK_BLOCKS - 1 && blk_fill == BLK_BYTES)
        begin
            total = chunk_ctr + 64'd1;
            push_subtree(low_half(compress(chain_cv, buffered_block(), chunk_ctr, 32'd64,
                                           chunk_end_flags())), total);
            start_chunk(total);
        end
        if (blk_fill >= BLK_BYTES)
        begin
            chain_cv = low_half(compress(chain_cv, buffered_block(), chunk_ctr, 32'd64,
                                         blks_in_chunk == 0 ? F_START : 32'd0));
            blks_in_chunk = (blks_in_chunk + 1) % 16;
            for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
            blk_fill = 0;
        end
        blk_bytes[blk_fill % 64] = b;
        blk_fill++;
    endtask

    // Fold the stack into the root and queue the four digest words.
    task automatic close_message();
        cv_t         ocv;
        msg_t        oblk;
        msg_t        w;
        word_t       olen;
        word_t       oflags;
        logic [63:0] octr;
        int          k;
        out_req_t    dw;
        ocv    = chain_cv;
        oblk   = buffered_block();
        olen   = word_t'(blk_fill);
        oflags = chunk_end_flags();
        octr   = chunk_ctr;
        k      = subtree_depth;
        while (k > 0)
        begin
            k--;
            w      = compress(ocv, oblk, octr, olen, oflags);
            ocv    = IV_WORDS;
            oblk   = join_cvs(subtree_cv[k], low_half(w));
            olen   = 32'd64;
            octr   = 64'd0;
            oflags = F_PARENT;
        end
        w = compress(ocv, oblk, 64'd0, olen, oflags | F_ROOT);
        for (int i = 0; i < 4; i++)
        begin
            dw.digest_word = {w[2*i+1], w[2*i]};
            dw.word_index  = 2'(i);
            dw.last_word   = (i == 3);
            dw.overflow    = stack_overflow;
            digest_q.push_back(dw);
        end
        clear_hasher();
    endtask

    task automatic take_request(in_req_t r);
        if (r.kind == KIND_NONE)
            return;
        if (r.kind == KIND_END)
        begin
            close_message();
            return;
        end
        hash_byte(r.data_byte);
        if (r.kind == KIND_LAST)
            close_message();
    endtask

    // Queue one message: n bytes, closed by a final byte or by a separate end.
    task automatic add_message(int n, bit by_end, bit drain, bit noise);
        feed_t f;
        bit    first;
        first = 1'b1;
        if (n == 0)
            by_end = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (noise && $urandom_range(0, 19) == 0)
            begin
                f.drain = drain && first;
                f.req   = '{kind: KIND_NONE, data_byte: 8'($urandom)};
                feed_q.push_back(f);
                first = 1'b0;
            end
            f.drain = drain && first;
            f.req.kind      = (i == n - 1 && !by_end) ? KIND_LAST : KIND_BYTE;
            f.req.data_byte = 8'($urandom);
            feed_q.push_back(f);
            first = 1'b0;
        end
        if (by_end)
        begin
            f.drain = drain && first;
            f.req   = '{kind: KIND_END, data_byte: 8'($urandom)};
            feed_q.push_back(f);
        end
    endtask

    // Driver: account for the accepted request, then present the next one.
    always @(posedge clk or negedge rst_n)
    begin
        feed_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                take_request(in_data);
            calm <= (feed_q.size() < 120);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (feed_q.size() > 0 && !(feed_q[0].drain && digest_q.size() > 0))
                begin
                    nxt = feed_q.pop_front();
                    in_data  <= nxt.req;
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        gap_left <= $urandom_range(1, 7);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted digest word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        out_req_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (out_data.digest_word !== want.digest_word)
                    begin
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 want.digest_word, out_data.digest_word);
                        fail_count++;
                    end
                    if (out_data.word_index !== want.word_index)
                    begin
                        $display("%0t: word_index expected %0d actual %0d", $time,
                                 want.word_index, out_data.word_index);
                        fail_count++;
                    end
                    if (out_data.last_word !== want.last_word)
                    begin
                        $display("%0t: last_word expected %b actual %b", $time,
                                 want.last_word, out_data.last_word);
                        fail_count++;
                    end
                    if (out_data.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 want.overflow, out_data.overflow);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 6);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int n;
        clear_hasher();

        // Directed: empty message, single extreme bytes, ignored kind, a byte closed by an end,
        // a drained three-byte message, exactly one block and one block plus a byte.
        add_message(0, 1'b1, 1'b0, 1'b0);
        feed_q.push_back('{drain: 1'b0, req: '{kind: KIND_LAST, data_byte: 8'h00}});
        feed_q.push_back('{drain: 1'b0, req: '{kind: KIND_LAST, data_byte: 8'hFF}});
        feed_q.push_back('{drain: 1'b0, req: '{kind: KIND_NONE, data_byte: 8'hA5}});
        feed_q.push_back('{drain: 1'b0, req: '{kind: KIND_BYTE, data_byte: 8'h80}});
        feed_q.push_back('{drain: 1'b0, req: '{kind: KIND_END, data_byte: 8'h7F}});
        add_message(3, 1'b1, 1'b1, 1'b0);
        add_message(64, 1'b0, 1'b0, 1'b0);
        add_message(65, 1'b1, 1'b0, 1'b0);

        // Random messages, mostly short, some spanning blocks.
        while (feed_q.size() < TOTAL_REQS)
        begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 20);
            if (n > TOTAL_REQS - feed_q.size())
                n = TOTAL_REQS - feed_q.size();
            add_message(n, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0, 1'b1);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests out, all digests back, then a quiet tail.
        while (feed_q.size() > 0 || in_valid || digest_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: blake3_256_hasher.f
+incdir+sv
sv/b3h_pkg.sv
sv/b3h_compress.sv
sv/blake3_256_hasher.sv
tb/tb_blake3_256_hasher.sv
